// ===== src/bbe_pkg.sv =====
// ----------------------------------------------------------------------------
// bbe_pkg
// shared constants, types and tables of the edge-aware 3x3 box blur
// ----------------------------------------------------------------------------
package bbe_pkg;

    localparam int MAX_WIDTH  = 1024;

    localparam int PIX_W      = 8;
    localparam int RGB_W      = 3 * PIX_W;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 1;

    localparam int W_W        = $clog2(MAX_WIDTH + 1);
    localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CNT_W      = W_W + 1;
    localparam int RING_DEPTH = 2 ** $clog2(2 * MAX_WIDTH + 3);
    localparam int RING_AW    = $clog2(RING_DEPTH);

    localparam int SUM_W      = 12;
    localparam int N_W        = 4;
    localparam int X_W        = SUM_W + 1;
    localparam int M_W        = 18;
    localparam int REC_SHIFT  = 18;
    localparam int PROD_W     = X_W + M_W;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [1:0] OFS_LO  = 2'd0;
    localparam logic [1:0] OFS_MID = 2'd1;
    localparam logic [1:0] OFS_HI  = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_LAST = 5'b00100,
        S_MUL  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    typedef logic [SUM_W-1:0]  t_sum3 [3];
    typedef logic [PROD_W-1:0] t_prod3 [3];

    // ceil(2^18 / (2n)), exact floor for every rounded mean of up to nine bytes
    function automatic logic [M_W-1:0] recip(input logic [N_W-1:0] n);
        logic [M_W-1:0] m;
        case (n)
            4'd1:    m = 18'd131072;
            4'd2:    m = 18'd65536;
            4'd3:    m = 18'd43691;
            4'd4:    m = 18'd32768;
            4'd6:    m = 18'd21846;
            4'd9:    m = 18'd14564;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

// ===== src/bbe_in_if.sv =====
// ----------------------------------------------------------------------------
// bbe_in_if
// input item channel: opcode and one rgb pixel
// ----------------------------------------------------------------------------
interface bbe_in_if
    import bbe_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [PIX_W-1:0] in_red;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_blue;

    modport source (output valid, opcode, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, opcode, in_red, in_green, in_blue, output ready);
endinterface

// ===== src/bbe_out_if.sv =====
// ----------------------------------------------------------------------------
// bbe_out_if
// result item channel: blurred rgb pixel and frame end mark
// ----------------------------------------------------------------------------
interface bbe_out_if
    import bbe_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
    logic             frame_last;

    modport source (output valid, out_red, out_green, out_blue, frame_last, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface

// ===== src/box_blur_3x3_edge_aware_unit.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_unit
// 3x3 box blur over a raster rgb stream, out-of-frame neighbors excluded
// ----------------------------------------------------------------------------
// Pixels of one frame enter in raster order and are kept in a ring line
// store of 2*frame_width+3 or more entries. An item that stores a pixel
// without releasing a result is only written to the line store. An item
// that releases a result (any item after the pixel frame_width+1 positions
// ahead has arrived, and every item once the frame is complete) starts a
// pass: the nine neighbors are read one per cycle through the single read
// port of the line store, then the sums are finished, one reciprocal multiply
// follows and the output register is loaded once it is free. Flush items
// before the frame is complete are dropped. A register write restarts the
// frame; widths above the supported maximum are clamped and zero sizes act as one.
module box_blur_3x3_edge_aware_unit
    import bbe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    bbe_in_if.sink               i_in,
    bbe_out_if.source            o_out
);
    t_state               r_state, n_state;
    logic [W_W-1:0]       r_width;
    logic [FH_W-1:0]      r_height;

    logic [RING_AW-1:0]   r_wr_addr;
    logic [CNT_W-1:0]     r_in_cnt;
    logic [COL_W-1:0]     r_in_col;
    logic [FH_W-1:0]      r_in_row;
    logic                 r_in_done;

    logic [RING_AW-1:0]   r_out_addr;
    logic [COL_W-1:0]     r_out_col;
    logic [FH_W-1:0]      r_out_row;

    logic [RING_AW-1:0]   r_row_base;
    logic [1:0]           r_dr;
    logic [1:0]           r_dc;
    logic                 r_rd_valid;
    t_sum3                r_sum;
    logic [N_W-1:0]       r_n;
    t_prod3               r_prod;

    logic                 r_out_valid;
    logic [PIX_W-1:0]     r_out_red;
    logic [PIX_W-1:0]     r_out_green;
    logic [PIX_W-1:0]     r_out_blue;
    logic                 r_out_last;

    logic                 in_acc;
    logic                 wr_en;
    logic                 start;
    logic                 in_col_last;
    logic                 in_row_last;
    logic                 out_col_last;
    logic                 out_row_last;
    logic                 row_ok;
    logic                 col_ok;
    logic                 out_free;
    logic [CNT_W-1:0]     prime_cnt;
    logic [RING_AW-1:0]   rd_addr;
    logic [RGB_W-1:0]     rd_data;
    logic [FW_W-1:0]      cfg_w;
    logic [FH_W-1:0]      cfg_h;
    logic [X_W-1:0]       x_val [3];
    logic [M_W-1:0]       m_val;

    assign in_acc       = i_in.valid && (r_state == S_IDLE);
    assign wr_en        = in_acc && !r_in_done && (i_in.opcode == OP_PIXEL);
    assign prime_cnt    = CNT_W'(r_width) + CNT_W'(2);
    assign start        = in_acc && (r_in_done ||
                          (wr_en && (r_in_cnt + 1'b1 == prime_cnt)) ||
                          (wr_en && (r_in_cnt == prime_cnt)));
    assign in_col_last  = (r_in_col == COL_W'(r_width - 1'b1));
    assign in_row_last  = (r_in_row == r_height - 1'b1);
    assign out_col_last = (r_out_col == COL_W'(r_width - 1'b1));
    assign out_row_last = (r_out_row == r_height - 1'b1);
    assign out_free     = !r_out_valid || o_out.ready;
    assign rd_addr      = r_row_base + RING_AW'(r_dc);
    assign cfg_w        = i_cfg_data[FW_W-1:0];
    assign cfg_h        = i_cfg_data[FH_W-1:0];

    always_comb begin
        case (r_dr)
            OFS_LO:  row_ok = (r_out_row != '0);
            OFS_MID: row_ok = 1'b1;
            OFS_HI:  row_ok = !out_row_last;
            default: row_ok = 1'b0;
        endcase
        case (r_dc)
            OFS_LO:  col_ok = (r_out_col != '0);
            OFS_MID: col_ok = 1'b1;
            OFS_HI:  col_ok = !out_col_last;
            default: col_ok = 1'b0;
        endcase
    end

    always_comb begin
        m_val = recip(r_n);
        for (int c = 0; c < 3; c++) begin
            x_val[c] = {r_sum[c], 1'b0} + X_W'(r_n);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_READ;
            end
            S_READ: begin
                if (r_dr == OFS_HI && r_dc == OFS_HI) n_state = S_LAST;
            end
            S_LAST:  n_state = S_MUL;
            S_MUL:   n_state = S_FIN;
            S_FIN: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    bbe_ram #(
        .DATA_W (RGB_W),
        .DEPTH  (RING_DEPTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wr_addr),
        .i_wr_data ({i_in.in_red, i_in.in_green, i_in.in_blue}),
        .i_rd_en   (r_state == S_READ),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_width     <= W_W'(1);
            r_height    <= FH_W'(1);
            r_wr_addr   <= '0;
            r_in_cnt    <= '0;
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_in_done   <= 1'b0;
            r_out_addr  <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_dr        <= '0;
            r_dc        <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (o_out.ready && r_state != S_FIN) r_out_valid <= 1'b0;

            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_FRAME_WIDTH: begin
                        if (cfg_w == '0) begin
                            r_width <= W_W'(1);
                        end else if (int'(cfg_w) > MAX_WIDTH) begin
                            r_width <= W_W'(MAX_WIDTH);
                        end else begin
                            r_width <= W_W'(cfg_w);
                        end
                    end
                    CFG_FRAME_HEIGHT: begin
                        r_height <= (cfg_h == '0) ? FH_W'(1) : cfg_h;
                    end
                    default: ;
                endcase
                r_wr_addr  <= '0;
                r_in_cnt   <= '0;
                r_in_col   <= '0;
                r_in_row   <= '0;
                r_in_done  <= 1'b0;
                r_out_addr <= '0;
                r_out_col  <= '0;
                r_out_row  <= '0;
            end

            if (wr_en) begin
                r_wr_addr <= r_wr_addr + 1'b1;
                if (r_in_cnt != prime_cnt) r_in_cnt <= r_in_cnt + 1'b1;
                if (in_col_last) begin
                    r_in_col <= '0;
                    if (in_row_last) begin
                        r_in_done <= 1'b1;
                    end else begin
                        r_in_row <= r_in_row + 1'b1;
                    end
                end else begin
                    r_in_col <= r_in_col + 1'b1;
                end
            end

            if (start) begin
                r_dr       <= OFS_LO;
                r_dc       <= OFS_LO;
                r_rd_valid <= 1'b0;
            end else if (r_state == S_READ) begin
                r_rd_valid <= row_ok && col_ok;
                if (r_dc == OFS_HI) begin
                    r_dc <= OFS_LO;
                    r_dr <= r_dr + 1'b1;
                end else begin
                    r_dc <= r_dc + 1'b1;
                end
            end else begin
                r_rd_valid <= 1'b0;
            end

            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
                if (out_col_last && out_row_last) begin
                    r_wr_addr  <= '0;
                    r_in_cnt   <= '0;
                    r_in_col   <= '0;
                    r_in_row   <= '0;
                    r_in_done  <= 1'b0;
                    r_out_addr <= '0;
                    r_out_col  <= '0;
                    r_out_row  <= '0;
                end else begin
                    r_out_addr <= r_out_addr + 1'b1;
                    if (out_col_last) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + 1'b1;
                    end else begin
                        r_out_col <= r_out_col + 1'b1;
                    end
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_row_base <= r_out_addr - RING_AW'(r_width) - 1'b1;
            r_n        <= '0;
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= '0;
            end
        end else begin
            if (r_state == S_READ && r_dc == OFS_HI) begin
                r_row_base <= r_row_base + RING_AW'(r_width);
            end
            if (r_rd_valid) begin
                r_n <= r_n + 1'b1;
                for (int c = 0; c < 3; c++) begin
                    r_sum[c] <= r_sum[c] + SUM_W'(rd_data[(2 - c) * PIX_W +: PIX_W]);
                end
            end
        end

        if (r_state == S_MUL) begin
            for (int c = 0; c < 3; c++) begin
                r_prod[c] <= PROD_W'(x_val[c]) * PROD_W'(m_val);
            end
        end

        if (r_state == S_FIN && out_free) begin
            r_out_red   <= r_prod[0][REC_SHIFT +: PIX_W];
            r_out_green <= r_prod[1][REC_SHIFT +: PIX_W];
            r_out_blue  <= r_prod[2][REC_SHIFT +: PIX_W];
            r_out_last  <= out_col_last && out_row_last;
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.out_red    = r_out_red;
    assign o_out.out_green  = r_out_green;
    assign o_out.out_blue   = r_out_blue;
    assign o_out.frame_last = r_out_last;
endmodule

// ===== src/bbe_ram.sv =====
// ----------------------------------------------------------------------------
// bbe_ram
// generic single-clock ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bbe_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data
);
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule
